// File: rtl/mbps_pkg.sv
`default_nettype none
package mbps_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int CFG_W       = 7;
  localparam int VAL_W       = 8;
  localparam int OUT_OFF_W   = 32;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [5:0]       entry_index;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] care_mask;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] match_offset;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/mbps_in_reg.sv
`default_nettype none
module mbps_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire mbps_pkg::item_t in_item,
  input  wire logic           fire,
  output logic                in_stall,
  output logic                s1_valid,
  output mbps_pkg::item_t     s1_item
);
  import mbps_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  accept;

  // hold the stage while its transaction cannot move on
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule
`default_nettype wire

// File: rtl/mbps_match.sv
`default_nettype none
module mbps_match (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       item_valid,
  input  wire mbps_pkg::item_t            item,
  input  wire logic                       fire,
  input  wire logic [mbps_pkg::CFG_W-1:0] pattern_length,
  output logic                            res_valid,
  output mbps_pkg::result_t               result
);
  import mbps_pkg::*;

  logic [VAL_W-1:0]       pat_r [PATTERN_MAX];
  logic [VAL_W-1:0]       msk_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pm_r, pm_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic                   reported_r, reported_nxt;

  logic [LEN_W-1:0]       len_act;
  logic [LEN_W-1:0]       len_m1;
  logic [PATTERN_MAX-1:0] pos_ok;
  logic [PATTERN_MAX-1:0] pm_adv;
  logic                   is_data;
  logic                   active;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;

  // clamp length: zero acts as one, large values saturate
  always_comb begin
    if (pattern_length == '0) begin
      len_act = LEN_W'(1);
    end else if (32'(pattern_length) > 32'(PATTERN_MAX)) begin
      len_act = LEN_W'(PATTERN_MAX);
    end else begin
      len_act = LEN_W'(pattern_length);
    end
  end

  assign len_m1 = len_act - LEN_W'(1);

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pos_ok[j] = (((item.value ^ pat_r[j]) & msk_r[j]) == '0) &&
                  (LEN_W'(j) < len_act);
    end
  end

  assign pm_adv  = {pm_r[PATTERN_MAX-2:0], 1'b1} & pos_ok;
  assign hit     = pm_adv[len_m1[IDX_W-1:0]];
  assign is_data = item_valid && (item.cmd == CMD_DATA);
  assign active  = is_data && !reported_r;

  assign start = (off_r == OFFSET_MAX) ? OFFSET_MAX
                                       : off_r - OFFSET_BITS'(len_m1);

  assign res_valid           = active && (hit || item.last_byte);
  assign result.found        = hit;
  assign result.match_offset = hit ? OUT_OFF_W'(start) : '0;

  always_comb begin
    pm_nxt       = pm_r;
    off_nxt      = off_r;
    reported_nxt = reported_r;
    if (fire && is_data) begin
      if (!reported_r) begin
        pm_nxt       = pm_adv;
        reported_nxt = hit;
      end
      if (off_r != OFFSET_MAX) begin
        off_nxt = off_r + OFFSET_BITS'(1);
      end
      // end of stream: rearm
      if (item.last_byte) begin
        pm_nxt       = '0;
        off_nxt      = '0;
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r       <= '0;
      off_r      <= '0;
      reported_r <= 1'b0;
    end else begin
      pm_r       <= pm_nxt;
      off_r      <= off_nxt;
      reported_r <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item_valid && (item.cmd == CMD_WRITE)) begin
      pat_r[item.entry_index] <= item.value;
      msk_r[item.entry_index] <= item.care_mask;
    end
  end

  a_frozen_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_data && reported_r && !item.last_byte |=> $stable(pm_r))
    else $error("prefix bits moved after the match was reported");

  a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_data && item.last_byte |=> (off_r == '0) && !reported_r && (pm_r == '0))
    else $error("stream end did not rearm the search");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> !res_valid)
    else $error("second result in one stream");

  a_hit_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && active && hit && !item.last_byte |=> reported_r)
    else $error("match not recorded");

endmodule
`default_nettype wire

// File: rtl/mbps_out_reg.sv
`default_nettype none
module mbps_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire mbps_pkg::result_t res_in,
  input  wire logic              out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output mbps_pkg::result_t      res_out
);
  import mbps_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

// File: rtl/masked_byte_pattern_search_top.sv
// A data byte that gives a result shows it on out_valid once the result register loads it.
// Throughput: one transaction per cycle, pattern writes and data bytes alike, while out_stall
//   is low; a single pass of masked compares and prefix-bit update follows the input register.
// Reset (rst_n low, synchronous): prefix bits, byte offset, match flag and valids clear,
//   pattern_length returns to 1; pattern and mask entries stay undefined until written.
`default_nettype none
module masked_byte_pattern_search_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mbps_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [5:0]                    in_entry_index,
  input  wire logic [7:0]                    in_value,
  input  wire logic [7:0]                    in_care_mask,
  input  wire logic                          in_last_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [mbps_pkg::OUT_OFF_W-1:0]     out_match_offset
);
  import mbps_pkg::*;

  logic [CFG_W-1:0] len_r;
  item_t            in_item;
  item_t            s1_item;
  logic             s1_valid;
  logic             res_valid;
  result_t          res;
  result_t          res_q;
  logic             out_free;
  logic             fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  assign in_item.cmd         = cmd_t'(in_cmd);
  assign in_item.entry_index = in_entry_index;
  assign in_item.value       = in_value;
  assign in_item.care_mask   = in_care_mask;
  assign in_item.last_byte   = in_last_byte;

  // advance when the stage gives no result or the result register can take it
  assign fire = s1_valid && (!res_valid || out_free);

  mbps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .fire     (fire),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  mbps_match u_match (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (s1_valid),
    .item           (s1_item),
    .fire           (fire),
    .pattern_length (len_r),
    .res_valid      (res_valid),
    .result         (res)
  );

  mbps_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .res_in    (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_found        = res_q.found;
  assign out_match_offset = res_q.match_offset;

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import mbps_pkg::*;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 6;
  localparam int ITEM_TARGET    = 850;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [5:0]           in_entry_index;
  logic [7:0]           in_value;
  logic [7:0]           in_care_mask;
  logic                 in_last_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_found;
  logic [OUT_OFF_W-1:0] out_match_offset;

  masked_byte_pattern_search_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_entry_index   (in_entry_index),
    .in_value         (in_value),
    .in_care_mask     (in_care_mask),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  // Shadow of the search state
  logic [VAL_W-1:0]       pat_byte [PATTERN_MAX];
  logic [VAL_W-1:0]       pat_care [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] prefix_hits = '0;
  logic [OFFSET_BITS-1:0] stream_pos = '0;
  bit                     hit_reported = 1'b0;
  logic [CFG_W-1:0]       length_reg = 7'd1;

  result_t expected_hits[$];
  result_t head_hit;
  int      n_errors = 0;
  int      items_sent = 0;
  bit      no_idle = 1'b0;
  bit      rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_len();
    if (length_reg == 0) return 1;
    if (length_reg > PATTERN_MAX) return PATTERN_MAX;
    return int'(length_reg);
  endfunction

  function automatic void predict_search(item_t it);
    int      len;
    result_t r;
    if (it.cmd == CMD_WRITE) begin
      pat_byte[it.entry_index] = it.value;
      pat_care[it.entry_index] = it.care_mask;
      return;
    end
    if (!hit_reported) begin
      len = active_len();
      prefix_hits = {prefix_hits[PATTERN_MAX-2:0], 1'b1};
      for (int j = 0; j < PATTERN_MAX; j++)
        if (j >= len || ((it.value ^ pat_byte[j]) & pat_care[j]) != 0)
          prefix_hits[j] = 1'b0;
      if (prefix_hits[len-1]) begin
        r.found = 1'b1;
        r.match_offset = (stream_pos == OFFSET_MAX) ? OFFSET_MAX
                                                    : stream_pos - OFFSET_BITS'(len - 1);
        expected_hits.push_back(r);
        hit_reported = 1'b1;
      end else if (it.last_byte) begin
        r.found = 1'b0;
        r.match_offset = '0;
        expected_hits.push_back(r);
      end
    end
    if (stream_pos != OFFSET_MAX) stream_pos++;
    if (it.last_byte) begin
      prefix_hits = '0;
      stream_pos = '0;
      hit_reported = 1'b0;
    end
  endfunction

  // Data byte that fits pattern position pos; spoil flips its lowest cared bit
  function automatic logic [7:0] fit_byte(int pos, bit spoil);
    logic [7:0] care;
    logic [7:0] b;
    care = pat_care[pos];
    b = (pat_byte[pos] & care) | (8'($urandom) & ~care);
    if (spoil) b ^= care & (~care + 8'd1);
    return b;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= it.cmd;
    in_entry_index <= it.entry_index;
    in_value       <= it.value;
    in_care_mask   <= it.care_mask;
    in_last_byte   <= it.last_byte;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_search(it);
  endtask

  task automatic send_entry(logic [5:0] idx, logic [7:0] v, logic [7:0] m);
    item_t it;
    it.cmd         = CMD_WRITE;
    it.entry_index = idx;
    it.value       = v;
    it.care_mask   = m;
    it.last_byte   = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] v, bit last);
    item_t it;
    it.cmd         = CMD_DATA;
    it.entry_index = 6'($urandom_range(0, 63));
    it.value       = v;
    it.care_mask   = 8'($urandom_range(0, 255));
    it.last_byte   = last;
    send_item(it);
  endtask

  // Drop valid and hold until every expected result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(logic [CFG_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    length_reg = v;
  endtask

  // Noise lead, optionally the pattern itself, then a noise tail
  task automatic send_stream(int lead, bit embed, bit corrupt, int tail);
    int         len;
    int         total;
    int         bad;
    logic [7:0] b;
    len   = active_len();
    total = lead + (embed ? len : 0) + tail;
    bad   = corrupt ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(0, 49) == 0)
        send_entry(6'($urandom_range(0, 63)), 8'($urandom), 8'($urandom));
      if (embed && k >= lead && k < lead + len)
        b = fit_byte(k - lead, (k - lead) == bad);
      else if ($urandom_range(0, 1) == 1)
        b = 8'($urandom);
      else
        b = fit_byte($urandom_range(0, len - 1), 1'b0);
      send_byte(b, k == total - 1);
    end
  endtask

  task automatic test_directed();
    send_entry(6'd0, 8'hA5, 8'hFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    // ignored after the hit; the last byte gives nothing
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    send_entry(6'd0, 8'hFF, 8'h00);
    send_byte(8'h00, 1'b1);
    set_length(7'd0);
    send_byte(8'hFF, 1'b1);
    set_length(7'd3);
    send_entry(6'd0, 8'h00, 8'hFF);
    send_entry(6'd1, 8'hFF, 8'hF0);
    send_entry(6'd2, 8'h3C, 8'h0F);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF7, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(8'hAC, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // pattern rewritten mid-stream takes effect on the next byte
    send_byte(8'h00, 1'b0);
    send_entry(6'd1, 8'h00, 8'hFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0C, 1'b1);
  endtask

  task automatic test_full_length();
    for (int i = 0; i < PATTERN_MAX; i++)
      send_entry(6'(i), 8'($urandom), 8'($urandom));
    set_length(7'd127);
    send_stream(3, 1'b1, 1'b0, 0);
    set_length(7'd64);
    send_stream(63, 1'b0, 1'b0, 0);
  endtask

  task automatic test_backpressure();
    set_length(7'd1);
    send_entry(6'd0, 8'($urandom), 8'h00);
    no_idle = 1'b1;
    rx_hold_req = 1'b1;
    repeat (30) send_byte(8'($urandom), 1'b1);
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random_streams();
    int               pick;
    int               kind;
    int               n_streams;
    logic [CFG_W-1:0] len_cfg;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       len_cfg = 7'd0;
        1:       len_cfg = 7'd127;
        2:       len_cfg = 7'd64;
        3:       len_cfg = 7'($urandom_range(17, 63));
        default: len_cfg = 7'($urandom_range(1, 8));
      endcase
      set_length(len_cfg);
      repeat ($urandom_range(0, 4))
        send_entry(6'($urandom_range(0, 63)), 8'($urandom), 8'($urandom));
      no_idle = ($urandom_range(0, 5) == 0);
      n_streams = (active_len() > 16) ? 2 : $urandom_range(4, 10);
      for (int s = 0; s < n_streams; s++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7)
          send_stream($urandom_range(0, 6), 1'b1, kind == 6, $urandom_range(0, 3));
        else
          send_stream($urandom_range(1, 12), 1'b0, 1'b0, 0);
        if ($urandom_range(0, 7) == 0) settle();
      end
      no_idle = 1'b0;
    end
  endtask

  // Receiver: stall per result for a drawn number of offers, or on rx_hold_req
  initial begin : result_receiver
    int n;
    int waited;
    int seen;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
          out_stall <= 1'b1;
          waited = 0;
          seen = 0;
          while (seen < n && waited < 16) begin
            @(posedge clk);
            waited++;
            if (out_valid) seen++;
          end
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !rx_hold_req);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected: found=%0b offset=%0d",
                 $time, out_found, out_match_offset);
      end else begin
        head_hit = expected_hits.pop_front();
        if (out_found !== head_hit.found) begin
          n_errors++;
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, head_hit.found, out_found);
        end
        if (out_match_offset !== head_hit.match_offset) begin
          n_errors++;
          $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                   $time, head_hit.match_offset, out_match_offset);
        end
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_cmd         <= CMD_DATA;
    in_entry_index <= '0;
    in_value       <= '0;
    in_care_mask   <= '0;
    in_last_byte   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_length();
    test_backpressure();
    test_random_streams();
    settle();
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
rtl/mbps_pkg.sv
rtl/mbps_in_reg.sv
rtl/mbps_match.sv
rtl/mbps_out_reg.sv
rtl/masked_byte_pattern_search_top.sv
sim/tb.sv
